// ===== hdl/acwa_pkg.sv =====
package acwa_pkg;
    localparam int unsigned DefEntries = 8;
    localparam int unsigned DefMaxAge  = 120;
    localparam logic [15:0] ArpMinLen  = 16'd28;
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_IPSRC  = 2'd1;
    localparam logic [1:0] REQ_ARP    = 2'd2;
    localparam logic [1:0] REQ_LOOKUP = 2'd3;
    localparam logic [15:0] OPC_REQUEST = 16'd1;
    localparam logic [15:0] OPC_REPLY   = 16'd2;
    localparam logic [1:0] CFG_OWN_IP  = 2'd0;
    localparam logic [1:0] CFG_MASK    = 2'd1;
    localparam logic [1:0] CFG_OWN_MAC = 2'd2;

    typedef struct packed {
        logic        any_match;
        logic        any_free;
        logic        hit;
        logic [47:0] mac;
        logic [7:0]  best_age;
    } t_scan;
endpackage

// ===== hdl/acwa_cell.sv =====
module acwa_cell #(
    parameter int unsigned IDX_W = 3,
    parameter int unsigned MAX_AGE = 120
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IDX_W-1:0]      i_idx,
    input  acwa_pkg::t_scan       i_scan,
    output acwa_pkg::t_scan       o_scan,
    output logic                  o_match,
    output logic                  o_free,
    output logic                  o_older,
    input  logic                  i_clear,
    input  logic                  i_tick,
    input  logic [7:0]            i_clock_next,
    input  logic                  i_write,
    input  logic [31:0]           i_key,
    input  logic [47:0]           i_mac,
    input  logic [7:0]            i_clock_now
);
    import acwa_pkg::*;

    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic [7:0]  r_stamp;
    logic [7:0]  age;
    logic [7:0]  age_next;

    assign age      = i_clock_now - r_stamp;
    assign age_next = i_clock_next - r_stamp;
    assign o_match  = (r_ip != '0) && (r_ip == i_key);
    assign o_free   = (r_ip == '0);
    assign o_older  = age > i_scan.best_age;

    always_comb begin
        o_scan = i_scan;
        o_scan.any_match = i_scan.any_match | o_match;
        o_scan.any_free  = i_scan.any_free | o_free;
        if (r_ip == i_key) begin
            o_scan.hit = 1'b1;
            o_scan.mac = r_mac;
        end
        if (o_older) begin
            o_scan.best_age = age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ip    <= '0;
            r_stamp <= '0;
        end else if (i_clear) begin
            if (i_tick && r_ip != '0 && age_next >= 8'(MAX_AGE)) begin
                r_ip <= '0;
            end
        end else if (i_write) begin
            r_ip    <= i_key;
            r_stamp <= i_clock_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_write && !i_clear) begin
            r_mac <= i_mac;
        end
    end

    logic unused;
    assign unused = ^i_idx;
endmodule

// ===== hdl/arp_cache_with_aging_unit.sv =====
// ARP cache with aging.
// Input channel: i_in_valid / o_in_stall carry one event per beat: a timer
// tick, a received IP source, a received ARP packet or a lookup.
// Output channel: o_out_valid / i_out_stall carry exactly one result beat per
// event: lookup outcome, or ARP reply fields for a request to our address;
// fields that do not apply are zero.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write own_ip, subnet_mask,
// own_mac; write only while idle.
// The table is a row of TABLE_ENTRIES cells; a scan record visits one cell per
// cycle, collecting match, free, oldest and lookup data.
// Sequence: after the accepting edge the scan visits all TABLE_ENTRIES cells,
// then the ST_DONE write state loads the result register, which drives the
// result beat. One event at a time: the next event is not taken before the
// write; o_in_stall is high from accept until the write.
// Reset empties the table and clears the clock; no clearing pass.
// When the receiver stalls, the result holds in the output register; the next
// event is still taken and scanned, then holds in its write cycle until the
// output register frees.
module arp_cache_with_aging_unit #(
    parameter int unsigned TABLE_ENTRIES = acwa_pkg::DefEntries,
    parameter int unsigned MAX_AGE = acwa_pkg::DefMaxAge
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_ip,
    input  logic [47:0] i_mac_addr,
    input  logic [31:0] i_target_ip,
    input  logic [15:0] i_arp_opcode,
    input  logic [15:0] i_arp_len,
    input  logic [15:0] i_hw_type,
    input  logic [15:0] i_proto_type,
    input  logic [7:0]  i_hw_len,
    input  logic [7:0]  i_proto_len,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_lookup_hit,
    output logic [47:0] o_lookup_mac,
    output logic        o_send_reply,
    output logic [15:0] o_reply_hw_type,
    output logic [15:0] o_reply_proto_type,
    output logic [7:0]  o_reply_hw_len,
    output logic [7:0]  o_reply_proto_len,
    output logic [47:0] o_reply_dest_mac,
    output logic [31:0] o_reply_dest_ip
);
    import acwa_pkg::*;

    localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [31:0] r_own_ip, r_mask;
    logic [47:0] r_own_mac;
    logic [1:0]  r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [7:0]  r_clock;
    logic [1:0]  r_req;
    logic        r_record, r_reply;
    logic [31:0] r_ip;
    logic [47:0] r_mac;
    logic [15:0] r_hwt, r_prt;
    logic [7:0]  r_hwl, r_prl;
    t_scan       r_scan;
    logic [IDX_W-1:0] r_free_idx, r_old_idx, r_match_idx;
    logic        r_out_valid;
    logic        r_out_hit;
    logic [47:0] r_out_mac;
    logic        r_out_reply;
    logic [15:0] r_out_hwt, r_out_prt;
    logic [7:0]  r_out_hwl, r_out_prl;
    logic [47:0] r_out_dmac;
    logic [31:0] r_out_dip;

    t_scan            scan_out [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] match_v, free_v, older_v, write_v;
    logic [IDX_W-1:0] cur;
    logic [IDX_W-1:0] tgt;
    logic             tick_apply, write_apply, done_go;
    logic             accept, is_req, rec;
    logic             lk_hit;

    assign cur = r_cnt[IDX_W-1:0];
    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign done_go = (r_state == ST_DONE) && (!r_out_valid || !i_out_stall);

    always_comb begin
        is_req = 1'b0;
        rec    = 1'b0;
        case (i_req_type)
            REQ_IPSRC: rec = ((i_ip & r_mask) == (r_own_ip & r_mask));
            REQ_ARP: begin
                if (i_arp_len >= ArpMinLen && i_target_ip == r_own_ip) begin
                    is_req = (i_arp_opcode == OPC_REQUEST);
                    rec    = is_req || (i_arp_opcode == OPC_REPLY);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        if (r_scan.any_match) begin
            tgt = r_match_idx;
        end else if (r_scan.any_free) begin
            tgt = r_free_idx;
        end else begin
            tgt = r_old_idx;
        end
    end

    assign tick_apply  = done_go && (r_req == REQ_TICK);
    assign write_apply = done_go && r_record;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            assign write_v[g] = write_apply && (tgt == IDX_W'(g));
            acwa_cell #(.IDX_W(IDX_W), .MAX_AGE(MAX_AGE)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_idx        (IDX_W'(g)),
                .i_scan       (r_scan),
                .o_scan       (scan_out[g]),
                .o_match      (match_v[g]),
                .o_free       (free_v[g]),
                .o_older      (older_v[g]),
                .i_clear      (tick_apply),
                .i_tick       (tick_apply),
                .i_clock_next (r_clock + 8'd1),
                .i_write      (write_v[g]),
                .i_key        (r_ip),
                .i_mac        (r_mac),
                .i_clock_now  (r_clock)
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip  <= '0;
            r_mask    <= '0;
            r_own_mac <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OWN_IP:  r_own_ip  <= i_cfg_data[31:0];
                CFG_MASK:    r_mask    <= i_cfg_data[31:0];
                CFG_OWN_MAC: r_own_mac <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_clock     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (done_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_SCAN;
                        r_cnt   <= '0;
                    end
                end
                ST_SCAN: begin
                    if (r_cnt == CNT_W'(TABLE_ENTRIES - 1)) begin
                        r_state <= ST_DONE;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                ST_DONE: begin
                    if (done_go) begin
                        if (r_req == REQ_TICK) begin
                            r_clock <= r_clock + 8'd1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= i_req_type;
            r_record <= rec;
            r_reply  <= is_req;
            r_ip     <= i_ip;
            r_mac    <= i_mac_addr;
            r_hwt    <= i_hw_type;
            r_prt    <= i_proto_type;
            r_hwl    <= i_hw_len;
            r_prl    <= i_proto_len;
            r_scan   <= '0;
            r_free_idx  <= '0;
            r_old_idx   <= '0;
            r_match_idx <= '0;
        end else if (r_state == ST_SCAN) begin
            r_scan <= scan_out[cur];
            if (match_v[cur] && !r_scan.any_match) begin
                r_match_idx <= cur;
            end
            if (free_v[cur] && !r_scan.any_free) begin
                r_free_idx <= cur;
            end
            if (older_v[cur]) begin
                r_old_idx <= cur;
            end
        end
    end

    assign lk_hit = (r_req == REQ_LOOKUP) && (r_ip != '0) && r_scan.hit;

    always_ff @(posedge i_clk) begin
        if (done_go) begin
            r_out_hit   <= lk_hit;
            r_out_mac   <= lk_hit ? r_scan.mac : '0;
            r_out_reply <= r_reply;
            r_out_hwt   <= r_reply ? r_hwt : '0;
            r_out_prt   <= r_reply ? r_prt : '0;
            r_out_hwl   <= r_reply ? r_hwl : '0;
            r_out_prl   <= r_reply ? r_prl : '0;
            r_out_dmac  <= r_reply ? r_mac : '0;
            r_out_dip   <= r_reply ? r_ip : '0;
        end
    end

    assign o_lookup_hit       = r_out_hit;
    assign o_lookup_mac       = r_out_mac;
    assign o_send_reply       = r_out_reply;
    assign o_reply_hw_type    = r_out_hwt;
    assign o_reply_proto_type = r_out_prt;
    assign o_reply_hw_len     = r_out_hwl;
    assign o_reply_proto_len  = r_out_prl;
    assign o_reply_dest_mac   = r_out_dmac;
    assign o_reply_dest_ip    = r_out_dip;

    logic unused;
    assign unused = ^r_own_mac;
endmodule
